[sv/mmp_pkg.sv]
// Package with the types and constants of the Michaelis-Menten propensity block.
package mmp_pkg;

  localparam int MAX_COUNT_BITS = 32;
  localparam int REG_BITS       = 32;
  localparam int FREE_BITS      = 36;
  localparam int PROP_BITS      = 52;

  localparam logic [0:0] CFG_KM   = 1'b0;
  localparam logic [0:0] CFG_KCAT = 1'b1;

  localparam logic [REG_BITS-1:0]  KM_RESET   = 32'h0001_0000;
  localparam logic [REG_BITS-1:0]  KCAT_RESET = 32'h0001_0000;
  localparam logic [FREE_BITS-1:0] FREE_MAX   = '1;
  localparam logic [PROP_BITS-1:0] PROP_MAX   = '1;

  typedef struct packed {
    logic [MAX_COUNT_BITS-1:0] substrate_count;
    logic [MAX_COUNT_BITS-1:0] enzyme_count;
  } in_t;

  typedef struct packed {
    logic [FREE_BITS-1:0] free_substrate;
    logic [PROP_BITS-1:0] propensity;
  } out_t;

endpackage

[sv/mmp_mul.sv]
// Pipelined multiplier that adds one 16-bit slice of the second operand per stage.
module mmp_mul #(
  parameter int AW = 32,
  parameter int BW = 32,
  parameter int SW = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_v,
  input  logic [AW-1:0]    in_a,
  input  logic [BW-1:0]    in_b,
  input  logic [SW-1:0]    in_side,
  output logic             out_v,
  output logic [AW+BW-1:0] out_p,
  output logic [SW-1:0]    out_side
);
  localparam int NS = (BW + 15) / 16;
  localparam int PW = AW + BW;
  localparam int BPW = NS * 16;

  logic          v_r    [0:NS];
  logic [AW-1:0] a_r    [0:NS];
  logic [BPW-1:0] b_r   [0:NS];
  logic [PW-1:0] acc_r  [0:NS];
  logic [SW-1:0] side_r [0:NS];

  assign v_r[0]    = in_v;
  assign a_r[0]    = in_a;
  assign b_r[0]    = BPW'(in_b);
  assign acc_r[0]  = '0;
  assign side_r[0] = in_side;

  for (genvar i = 0; i < NS; i++) begin : g_stage
    logic [AW+15:0] pp;
    logic [PW-1:0]  acc_nxt;

    always_comb begin
      pp      = (AW+16)'(a_r[i]) * (AW+16)'(b_r[i][16*i +: 16]);
      acc_nxt = acc_r[i] + (PW'(pp) << (16 * i));
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (en) begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        a_r[i+1]    <= a_r[i];
        b_r[i+1]    <= b_r[i];
        acc_r[i+1]  <= acc_nxt;
        side_r[i+1] <= side_r[i];
      end
    end
  end

  assign out_v    = v_r[NS];
  assign out_p    = acc_r[NS];
  assign out_side = side_r[NS];

endmodule

[sv/mmp_sqrt.sv]
// Pipelined integer square root that settles one root bit per stage.
module mmp_sqrt #(
  parameter int XW = 64,
  parameter int SW = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_v,
  input  logic [XW-1:0]    in_x,
  input  logic [SW-1:0]    in_side,
  output logic             out_v,
  output logic [XW/2-1:0]  out_root,
  output logic [SW-1:0]    out_side
);
  localparam int RTW  = XW / 2;
  localparam int REMW = RTW + 3;

  logic            v_r    [0:RTW];
  logic [XW-1:0]   x_r    [0:RTW];
  logic [RTW-1:0]  root_r [0:RTW];
  logic [REMW-1:0] rem_r  [0:RTW];
  logic [SW-1:0]   side_r [0:RTW];

  assign v_r[0]    = in_v;
  assign x_r[0]    = in_x;
  assign root_r[0] = '0;
  assign rem_r[0]  = '0;
  assign side_r[0] = in_side;

  for (genvar i = 0; i < RTW; i++) begin : g_stage
    logic [REMW+1:0] r2;
    logic [REMW+1:0] trial;
    logic            ge;

    always_comb begin
      r2    = {rem_r[i], x_r[i][XW-1 -: 2]};
      trial = (REMW+2)'({root_r[i], 2'b01});
      ge    = r2 >= trial;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (en) begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i+1]    <= x_r[i] << 2;
        root_r[i+1] <= {root_r[i][RTW-2:0], ge};
        rem_r[i+1]  <= ge ? REMW'(r2 - trial) : REMW'(r2);
        side_r[i+1] <= side_r[i];
      end
    end
  end

  assign out_v    = v_r[RTW];
  assign out_root = root_r[RTW];
  assign out_side = side_r[RTW];

endmodule

[sv/mmp_div.sv]
// Pipelined restoring divider that settles one quotient bit per stage.
module mmp_div #(
  parameter int NW = 64,
  parameter int DW = 32,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_v,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_v,
  output logic [NW-1:0] out_quo,
  output logic [SW-1:0] out_side
);
  logic          v_r    [0:NW];
  logic [NW-1:0] nq_r   [0:NW];
  logic [DW-1:0] den_r  [0:NW];
  logic [DW-1:0] rem_r  [0:NW];
  logic [SW-1:0] side_r [0:NW];

  assign v_r[0]    = in_v;
  assign nq_r[0]   = in_num;
  assign den_r[0]  = in_den;
  assign rem_r[0]  = '0;
  assign side_r[0] = in_side;

  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic [DW:0] r2;
    logic        ge;

    always_comb begin
      r2 = {rem_r[i], nq_r[i][NW-1]};
      ge = r2 >= (DW+1)'(den_r[i]);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (en) begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nq_r[i+1]   <= {nq_r[i][NW-2:0], ge};
        den_r[i+1]  <= den_r[i];
        rem_r[i+1]  <= ge ? DW'(r2 - (DW+1)'(den_r[i])) : DW'(r2);
        side_r[i+1] <= side_r[i];
      end
    end
  end

  assign out_v    = v_r[NW];
  assign out_quo  = nq_r[NW];
  assign out_side = side_r[NW];

endmodule

[sv/michaelis_menten_propensity.sv]
// Michaelis-Menten propensity with the quadratic rate law. One request is taken
// in every cycle while the result port does not stall, and gives one result.
// The square root settles one bit per stage and the divider one quotient bit per
// stage, so these two set the depth. A stall at the result port holds the whole
// pipeline. The user is to write Km and kcat only while the block is empty; the
// block itself does not enforce this.
module michaelis_menten_propensity #(
  parameter int COUNT_BITS = 20
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  mmp_pkg::in_t           in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output mmp_pkg::out_t          out_data,
  input  logic                   cfg_we,
  input  logic [0:0]             cfg_idx,
  input  logic [31:0]            cfg_data
);
  import mmp_pkg::*;

  localparam int AW   = ((COUNT_BITS + 16 > 32) ? COUNT_BITS + 16 : 32) + 1;
  localparam int DSW  = AW + 1;
  localparam int RW   = 2 * AW + 2;
  localparam int RTW  = AW + 1;
  localparam int KW   = REG_BITS + COUNT_BITS;
  localparam int FW   = RTW;
  localparam int DENW = ((FW > REG_BITS) ? FW : REG_BITS) + 1;
  localparam int NUMW = KW + FW;
  localparam int S1W  = 1 + AW + KW + KW;
  localparam int S2W  = 1 + AW + KW;
  localparam int S3W  = DENW + FW;
  localparam int S4W  = 1 + FW;

  logic [REG_BITS-1:0] km_r;
  logic [REG_BITS-1:0] kcat_r;
  logic                en;
  logic                out_valid_r;
  out_t                out_data_r;
  out_t                out_data_nxt;

  assign en        = !out_valid_r || out_ready;
  assign in_ready  = en;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      km_r   <= KM_RESET;
      kcat_r <= KCAT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_KM:   km_r   <= cfg_data;
        CFG_KCAT: kcat_r <= cfg_data;
        default:  km_r   <= km_r;
      endcase
    end
  end

  // Stage A: signed offset d, its magnitude and the two products with the registers.
  logic [COUNT_BITS-1:0] s_c;
  logic [COUNT_BITS-1:0] e_c;
  logic signed [DSW-1:0] d_c;
  logic [AW-1:0]         dabs_c;
  logic                  va_r;
  logic                  neg_a_r;
  logic [AW-1:0]         dabs_a_r;
  logic [KW-1:0]         ks_a_r;
  logic [KW-1:0]         ke_a_r;

  always_comb begin
    s_c    = in_data.substrate_count[COUNT_BITS-1:0];
    e_c    = in_data.enzyme_count[COUNT_BITS-1:0];
    d_c    = $signed(DSW'({s_c, 16'b0})) - $signed(DSW'(km_r))
           - $signed(DSW'({e_c, 16'b0}));
    dabs_c = d_c[DSW-1] ? AW'(-d_c) : AW'(d_c);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_a_r  <= d_c[DSW-1];
      dabs_a_r <= dabs_c;
      ks_a_r   <= KW'(km_r) * KW'(s_c);
      ke_a_r   <= KW'(kcat_r) * KW'(e_c);
    end
  end

  logic            v1;
  logic [2*AW-1:0] sq1;
  logic [S1W-1:0]  side1;

  mmp_mul #(.AW(AW), .BW(AW), .SW(S1W)) u_sq (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (va_r),
    .in_a     (dabs_a_r),
    .in_b     (dabs_a_r),
    .in_side  ({neg_a_r, dabs_a_r, ks_a_r, ke_a_r}),
    .out_v    (v1),
    .out_p    (sq1),
    .out_side (side1)
  );

  // Stage B: the radicand.
  logic          vb_r;
  logic [RW-1:0] rad_b_r;
  logic [S2W-1:0] side_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (en) begin
      vb_r <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_b_r  <= RW'(sq1) + (RW'(side1[2*KW-1:KW]) << 18);
      side_b_r <= {side1[S1W-1 -: 1 + AW], side1[KW-1:0]};
    end
  end

  logic           v2;
  logic [RTW-1:0] root2;
  logic [S2W-1:0] side2;

  mmp_sqrt #(.XW(RW), .SW(S2W)) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (vb_r),
    .in_x     (rad_b_r),
    .in_side  (side_b_r),
    .out_v    (v2),
    .out_root (root2),
    .out_side (side2)
  );

  // Stage C: free substrate and the denominator.
  logic           neg2;
  logic [AW-1:0]  dabs2;
  logic [RTW:0]   sum_c;
  logic [FW-1:0]  sfree_c;
  logic           vc_r;
  logic [FW-1:0]  sfree_c_r;
  logic [DENW-1:0] den_c_r;
  logic [KW-1:0]  ke_c_r;

  always_comb begin
    neg2    = side2[S2W-1];
    dabs2   = side2[S2W-2 -: AW];
    sum_c   = neg2 ? (RTW+1)'(root2) - (RTW+1)'(dabs2)
                   : (RTW+1)'(root2) + (RTW+1)'(dabs2);
    sfree_c = sum_c[RTW:1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (en) begin
      vc_r <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sfree_c_r <= sfree_c;
      den_c_r   <= DENW'(km_r) + DENW'(sfree_c);
      ke_c_r    <= side2[KW-1:0];
    end
  end

  logic            v3;
  logic [NUMW-1:0] num3;
  logic [S3W-1:0]  side3;

  mmp_mul #(.AW(KW), .BW(FW), .SW(S3W)) u_num (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (vc_r),
    .in_a     (ke_c_r),
    .in_b     (sfree_c_r),
    .in_side  ({den_c_r, sfree_c_r}),
    .out_v    (v3),
    .out_p    (num3),
    .out_side (side3)
  );

  logic            v4;
  logic [NUMW-1:0] quo4;
  logic [S4W-1:0]  side4;

  mmp_div #(.NW(NUMW), .DW(DENW), .SW(S4W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (v3),
    .in_num   (num3),
    .in_den   (side3[S3W-1 -: DENW]),
    .in_side  ({side3[S3W-1 -: DENW] == '0, side3[FW-1:0]}),
    .out_v    (v4),
    .out_quo  (quo4),
    .out_side (side4)
  );

  // Output register with saturation of both fields and a zero propensity when the denominator is zero.
  always_comb begin
    if ((FW+FREE_BITS)'(side4[FW-1:0]) > (FW+FREE_BITS)'(FREE_MAX)) begin
      out_data_nxt.free_substrate = FREE_MAX;
    end else begin
      out_data_nxt.free_substrate = FREE_BITS'(side4[FW-1:0]);
    end
    if (side4[S4W-1]) begin
      out_data_nxt.propensity = '0;
    end else if ((NUMW+PROP_BITS)'(quo4) > (NUMW+PROP_BITS)'(PROP_MAX)) begin
      out_data_nxt.propensity = PROP_MAX;
    end else begin
      out_data_nxt.propensity = PROP_BITS'(quo4);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

[sv/mmp_checker.sv]
// Port checker for the Michaelis-Menten propensity block and its bind statement.
module mmp_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input mmp_pkg::out_t out_data
);
  import mmp_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or vanished");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("request ready does not follow the result stall");

  a_zero_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.free_substrate == '0 |-> out_data.propensity == '0)
    else $error("propensity non-zero with no free substrate");

endmodule

bind michaelis_menten_propensity mmp_checker u_mmp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

[sim/testbench.sv]
// Testbench that checks the Michaelis-Menten propensity block against its own predictor.
`timescale 1ns / 100ps

module testbench;
  import mmp_pkg::*;

  localparam int COUNT_BITS = 20;
  localparam int DRAIN_CYCLES = 200;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_idx = CFG_KM;
  logic [31:0] cfg_data = '0;

  in_t request_queue[$];
  out_t rate_queue[$];
  logic [31:0] km_now = KM_RESET;
  logic [31:0] kcat_now = KCAT_RESET;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;

  michaelis_menten_propensity #(.COUNT_BITS(COUNT_BITS)) dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic out_t predict_rate(in_t req);
    logic [63:0] s, e, dabs, root, cand, sfree, den, cnt_scale;
    logic signed [63:0] d;
    logic [127:0] rad, num, quo;
    out_t res;
    s = 64'(req.substrate_count[COUNT_BITS-1:0]);
    e = 64'(req.enzyme_count[COUNT_BITS-1:0]);
    d = $signed(s << 16) - $signed(64'(km_now)) - $signed(e << 16);
    dabs = d < 0 ? 64'(-d) : 64'(d);
    rad = 128'(dabs) * 128'(dabs) + ((128'(km_now) * 128'(s)) << 18);
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      if (128'(cand) * 128'(cand) <= rad) root = cand;
    end
    sfree = (d < 0 ? root - dabs : root + dabs) >> 1;
    den = 64'(km_now) + sfree;
    cnt_scale = 64'(kcat_now) * e;
    if (den == 0) begin
      quo = '0;
    end else begin
      num = 128'(cnt_scale) * 128'(sfree);
      quo = num / 128'(den);
    end
    res.free_substrate = sfree > 64'(FREE_MAX) ? FREE_MAX : sfree[FREE_BITS-1:0];
    res.propensity = quo > 128'(PROP_MAX) ? PROP_MAX : quo[PROP_BITS-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) rate_queue.push_back(predict_rate(in_data));
      if (!in_valid || in_ready) begin
        if (request_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= request_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (rate_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result %h", out_data);
        end else begin
          want = rate_queue.pop_front();
          if (out_data.free_substrate !== want.free_substrate ||
              out_data.propensity !== want.propensity) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: free %h prop %h, expected free %h prop %h",
                       out_data.free_substrate, out_data.propensity,
                       want.free_substrate, want.propensity);
          end
        end
      end
      out_ready <= $urandom_range(99) >= recv_stall_pct;
    end
  end

  task automatic write_reg(logic [0:0] idx, logic [31:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value;
    if (idx == CFG_KM) km_now <= value;
    else kcat_now <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_request(logic [31:0] s, logic [31:0] e);
    in_t req;
    req.substrate_count = s;
    req.enzyme_count = e;
    request_queue.push_back(req);
  endtask

  task automatic wait_empty();
    while (request_queue.size() > 0 || in_valid || rate_queue.size() > 0)
      @(posedge clk);
  endtask

  task automatic random_requests(int n);
    logic [31:0] s, e, hi;
    for (int i = 0; i < n; i++) begin
      hi = $urandom_range(3) == 0 ? $urandom() : 32'd0;
      case ($urandom_range(3))
        0: begin s = $urandom_range(255); e = $urandom_range(255); end
        1: begin s = $urandom_range(65535); e = $urandom_range(4095); end
        2: begin s = $urandom_range(1048575); e = s + $urandom_range(8) - 4; end
        default: begin s = $urandom(); e = $urandom(); end
      endcase
      s[31:COUNT_BITS] = hi[31:COUNT_BITS];
      e[31:COUNT_BITS] = ~hi[31:COUNT_BITS];
      add_request(s, e);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    add_request(0, 0);
    add_request(0, 32'hFFFFF);
    add_request(32'hFFFFF, 0);
    add_request(32'hFFFFF, 32'hFFFFF);
    add_request(1, 1);
    add_request(1, 0);
    add_request(2, 1);
    add_request(100, 100);
    add_request(32'hFFFFFFFF, 32'hFFFFFFFF);
    add_request(32'hFFF00000, 32'hFFF00000);
    add_request(32'hAAAAA, 32'h55555);
    add_request(32'h55555, 32'hAAAAA);
    random_requests(150);
    wait_empty();

    send_idle_pct = 73;
    write_reg(CFG_KM, 32'd1);
    write_reg(CFG_KCAT, 32'hFFFFFFFF);
    add_request(0, 0);
    add_request(0, 32'hFFFFF);
    add_request(32'hFFFFF, 32'hFFFFF);
    random_requests(160);
    wait_empty();

    send_idle_pct = 0;
    recv_stall_pct = 73;
    write_reg(CFG_KM, 32'hFFFFFFFF);
    write_reg(CFG_KCAT, 32'd0);
    add_request(32'hFFFFF, 32'hFFFFF);
    random_requests(160);
    wait_empty();

    send_idle_pct = 30;
    recv_stall_pct = 30;
    write_reg(CFG_KM, $urandom_range(32'h7FFFFFFF, 1));
    write_reg(CFG_KCAT, $urandom());
    random_requests(160);
    wait_empty();

    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_reg(CFG_KM, 32'h0000_8000);
    write_reg(CFG_KCAT, 32'h00FF_FFFF);
    random_requests(160);
    wait_empty();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && rate_queue.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
